FILE: rtl/core/rcakt_pkg.sv
// ----------------------------------------------------------------------------
// rcakt_pkg
// Shared types and constants of the reference-count aging key table.
// ----------------------------------------------------------------------------
package rcakt_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_W     = 32;
    localparam int CNT_W     = 16;
    localparam int HWM_W     = 7;
    localparam int LWM_W     = 6;
    localparam int TOT_W     = 7;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic OP_REF   = 1'b0;
    localparam logic OP_CLEAN = 1'b1;

    // register index as decoded from the address
    localparam logic REG_HWM = 1'b0;
    localparam logic REG_LWM = 1'b1;

    localparam logic [HWM_W-1:0] HWM_RESET = 7'd32;
    localparam logic [LWM_W-1:0] LWM_RESET = 6'd16;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_SKIPPED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_REF,
        S_CLEAN
    } t_state;

    typedef struct packed {
        logic                    op;
        logic signed [KEY_W-1:0] key;
        logic                    check_mark;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic               found;
        logic [CNT_W-1:0]   ref_value;
        logic [TOT_W-1:0]   entry_total;
        logic [TOT_W-1:0]   removed;
    } t_result;

    // one table entry; a count of zero marks a free slot
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_entry;

endpackage

FILE: rtl/core/rcakt_ram.sv
// ----------------------------------------------------------------------------
// rcakt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcakt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/refcount_aging_key_table.sv
// ----------------------------------------------------------------------------
// refcount_aging_key_table
// Key table with saturating reference counts and a clean pass that ages
// every entry, kept in one RAM that is walked one entry per cycle.
// ----------------------------------------------------------------------------
// Results: a refused reference or a skipped clean shows its result in the cycle
//   after the transfer; a reference that hits entry i finishes once entry i is
//   read; a miss (insert or full table) and a clean pass walk every entry.
// Throughput: one item at a time, set by the single RAM read port; start may
//   be given again in the cycle the result strobe shows. Results cannot stall.
// Reset: a clearing sweep over every slot zeroes the table, busy held high.
// ----------------------------------------------------------------------------
module refcount_aging_key_table #(
    parameter int CAPACITY = rcakt_pkg::CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  rcakt_pkg::t_cmd                   i_cmd,
    output logic                              o_done,
    output rcakt_pkg::t_result                o_result,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rcakt_pkg::APB_AW-1:0]      paddr,
    input  logic [rcakt_pkg::APB_DW-1:0]      pwdata,
    output logic [rcakt_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int TW = $clog2(CAPACITY + 1);
    localparam int CW = (TW > rcakt_pkg::TOT_W) ? TW : rcakt_pkg::TOT_W;
    localparam int EW = $bits(rcakt_pkg::t_entry);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    // truncate an internal total to the width of a result field
    function automatic logic [rcakt_pkg::TOT_W-1:0] to_field(input logic [TW-1:0] v);
        logic [CW-1:0] x;
        x = CW'(v);
        return x[rcakt_pkg::TOT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rcakt_pkg::HWM_W-1:0] r_hwm;
    logic [rcakt_pkg::LWM_W-1:0] r_lwm;
    logic                        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hwm <= rcakt_pkg::HWM_RESET;
            r_lwm <= rcakt_pkg::LWM_RESET;
        end else if (w_cfg_wr) begin
            // decode on the word address; byte offset bits are ignored
            if (paddr[2] == rcakt_pkg::REG_HWM) begin
                r_hwm <= pwdata[rcakt_pkg::HWM_W-1:0];
            end else begin
                r_lwm <= pwdata[rcakt_pkg::LWM_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == rcakt_pkg::REG_LWM) begin
            prdata = rcakt_pkg::APB_DW'(r_lwm);
        end else begin
            prdata = rcakt_pkg::APB_DW'(r_hwm);
        end
    end

    // ------------------------------------------------------------------
    // Table RAM: {key, count}, count of zero means free
    // ------------------------------------------------------------------
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    rcakt_pkg::t_entry     w_wdata;
    rcakt_pkg::t_entry     w_rdata;
    logic [AW-1:0]         r_ptr, n_ptr;

    rcakt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    rcakt_pkg::t_state           r_state, n_state;
    logic                        r_issue, n_issue;   // reads still to issue
    logic                        r_dv, n_dv;         // read data valid
    logic [AW-1:0]               r_dptr, n_dptr;     // address of read data
    logic                        r_free_vld, n_free_vld;
    logic [AW-1:0]               r_free, n_free;     // lowest free slot seen
    logic [TW-1:0]               r_total, n_total;
    logic [TW-1:0]               r_rem, n_rem;
    logic [rcakt_pkg::KEY_W-1:0] r_key, n_key;
    logic                        r_done, n_done;
    rcakt_pkg::t_result          r_res, n_res;

    // data path terms on the entry coming out of the RAM
    logic                        w_valid;
    logic                        w_hit;
    logic                        w_last;
    logic                        w_kill;
    logic [TW-1:0]               w_rem_all;
    logic [rcakt_pkg::CNT_W-1:0] w_inc;

    assign w_valid   = (w_rdata.count != '0);
    assign w_hit     = w_valid && (w_rdata.key == r_key);
    assign w_last    = (r_dptr == LAST);
    assign w_kill    = w_valid && (w_rdata.count <= rcakt_pkg::CNT_W'(1));
    assign w_rem_all = r_rem + TW'(w_kill);
    assign w_inc     = (w_rdata.count == rcakt_pkg::COUNT_MAX) ? w_rdata.count
                                                              : w_rdata.count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rcakt_pkg::S_CLEAR;
            r_ptr      <= '0;
            r_issue    <= 1'b0;
            r_dv       <= 1'b0;
            r_free_vld <= 1'b0;
            r_total    <= '0;
            r_rem      <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_issue    <= n_issue;
            r_dv       <= n_dv;
            r_free_vld <= n_free_vld;
            r_total    <= n_total;
            r_rem      <= n_rem;
            r_done     <= n_done;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_dptr <= n_dptr;
        r_free <= n_free;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_issue    = r_issue;
        n_dv       = 1'b0;
        n_dptr     = r_dptr;
        n_free_vld = r_free_vld;
        n_free     = r_free;
        n_total    = r_total;
        n_rem      = r_rem;
        n_key      = r_key;
        n_done     = 1'b0;
        n_res      = r_res;
        w_we       = 1'b0;
        w_waddr    = r_dptr;
        w_wdata    = w_rdata;

        case (r_state)
            rcakt_pkg::S_CLEAR: begin
                // sweep every slot to free
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = '0;
                if (r_ptr == LAST) begin
                    n_state = rcakt_pkg::S_IDLE;
                    n_ptr   = '0;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            rcakt_pkg::S_IDLE: begin
                if (start) begin
                    n_key             = r_key;
                    n_key             = i_cmd.key;
                    n_ptr             = '0;
                    n_issue           = 1'b1;
                    n_free_vld        = 1'b0;
                    n_rem             = '0;
                    n_res.found       = 1'b0;
                    n_res.ref_value   = '0;
                    n_res.removed     = '0;
                    n_res.entry_total = to_field(r_total);
                    if (i_cmd.op == rcakt_pkg::OP_REF) begin
                        if (CW'(r_total) >= CW'(r_hwm)) begin
                            // refuse before any search
                            n_done       = 1'b1;
                            n_res.status = rcakt_pkg::ST_REFUSED;
                        end else begin
                            n_state = rcakt_pkg::S_REF;
                        end
                    end else begin
                        if (i_cmd.check_mark && (CW'(r_total) <= CW'(r_lwm))) begin
                            n_done       = 1'b1;
                            n_res.status = rcakt_pkg::ST_SKIPPED;
                        end else begin
                            n_state = rcakt_pkg::S_CLEAN;
                        end
                    end
                end
            end

            rcakt_pkg::S_REF: begin
                // issue the next read
                n_dv = r_issue;
                if (r_issue) begin
                    n_dptr = r_ptr;
                    if (r_ptr == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
                if (r_dv) begin
                    if (w_hit) begin
                        // bump the count in place, saturating
                        w_we            = 1'b1;
                        w_waddr         = r_dptr;
                        w_wdata.key     = w_rdata.key;
                        w_wdata.count   = w_inc;
                        n_state         = rcakt_pkg::S_IDLE;
                        n_issue         = 1'b0;
                        n_dv            = 1'b0;
                        n_done          = 1'b1;
                        n_res.status    = rcakt_pkg::ST_DONE;
                        n_res.found     = 1'b1;
                        n_res.ref_value = w_inc;
                    end else begin
                        if (!w_valid && !r_free_vld) begin
                            n_free_vld = 1'b1;
                            n_free     = r_dptr;
                        end
                        if (w_last) begin
                            n_state = rcakt_pkg::S_IDLE;
                            n_done  = 1'b1;
                            if (r_free_vld || !w_valid) begin
                                // insert at the lowest free slot
                                w_we              = 1'b1;
                                w_waddr           = r_free_vld ? r_free : r_dptr;
                                w_wdata.key       = r_key;
                                w_wdata.count     = rcakt_pkg::CNT_W'(1);
                                n_total           = r_total + 1'b1;
                                n_res.status      = rcakt_pkg::ST_DONE;
                                n_res.ref_value   = rcakt_pkg::CNT_W'(1);
                                n_res.entry_total = to_field(r_total + 1'b1);
                            end else begin
                                n_res.status = rcakt_pkg::ST_REFUSED;
                            end
                        end
                    end
                end
            end

            rcakt_pkg::S_CLEAN: begin
                n_dv = r_issue;
                if (r_issue) begin
                    n_dptr = r_ptr;
                    if (r_ptr == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
                if (r_dv) begin
                    // age the entry: decrement, drop at zero
                    if (w_valid) begin
                        w_we          = 1'b1;
                        w_waddr       = r_dptr;
                        w_wdata.key   = w_rdata.key;
                        w_wdata.count = w_kill ? '0 : w_rdata.count - 1'b1;
                    end
                    n_rem = w_rem_all;
                    if (w_last) begin
                        n_state           = rcakt_pkg::S_IDLE;
                        n_done            = 1'b1;
                        n_total           = r_total - w_rem_all;
                        n_res.status      = rcakt_pkg::ST_DONE;
                        n_res.entry_total = to_field(r_total - w_rem_all);
                        n_res.removed     = to_field(w_rem_all);
                    end
                end
            end

            default: begin
                n_state = rcakt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != rcakt_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // the table never holds more entries than it has slots
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(CAPACITY))
        else $error("entry total above capacity");

    // a reference taken at or above the high mark is refused next cycle
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.op == rcakt_pkg::OP_REF)
         && (CW'(r_total) >= CW'(r_hwm)))
        |=> (o_done && (o_result.status == rcakt_pkg::ST_REFUSED)))
        else $error("reference at high mark not refused");

    // the table is only written by the sweep or a running op
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state != rcakt_pkg::S_IDLE))
        else $error("table write while idle");

    // a found key always reports a live count
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.found) |-> (o_result.ref_value != '0))
        else $error("found key with zero count");

    // a clean pass never grows the table
    a_clean_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcakt_pkg::S_CLEAN) |=> (r_total <= $past(r_total)))
        else $error("clean pass grew the table");
`endif

endmodule
